FILE: sv/mdexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by mdexp_ctrl, mdexp_datapath and modular_exponentiation; no dependencies.
package mdexp_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd1;

    localparam logic [1:0] OP_BASE = 2'd0;
    localparam logic [1:0] OP_ACC  = 2'd1;
    localparam logic [1:0] OP_SQR  = 2'd2;

    typedef logic [WORD_WIDTH-1:0] t_word;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic       mul_step;
        logic [1:0] op_sel;
        logic       wr_sq;
        logic       wr_acc;
        logic       shift_exp;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_exp_zero;
        logic exp_bit0;
        logic exp_bit1;
        logic exp_rest_zero;
        logic mul_last;
    } t_dp_stat;

endpackage

FILE: sv/mdexp_datapath.sv
// Datapath: operand registers, exponent shifter and the shift-add modular multiplier.
// Driven by mdexp_ctrl through mdexp_pkg::t_dp_cmd; reports mdexp_pkg::t_dp_stat.
module mdexp_datapath (
    input  logic               i_clk,
    input  mdexp_pkg::t_dp_cmd i_cmd,
    input  mdexp_pkg::t_word   i_base,
    input  mdexp_pkg::t_word   i_modulus,
    input  mdexp_pkg::t_word   i_exponent,
    output mdexp_pkg::t_dp_stat o_stat,
    output mdexp_pkg::t_word   o_acc
);

    localparam int W = mdexp_pkg::WORD_WIDTH;

    mdexp_pkg::t_word r_base;
    mdexp_pkg::t_word r_acc;
    mdexp_pkg::t_word r_sq;
    mdexp_pkg::t_word r_exp;
    mdexp_pkg::t_word r_mx;
    mdexp_pkg::t_word r_my;
    mdexp_pkg::t_word r_r;
    logic [mdexp_pkg::CNT_W-1:0] r_cnt;

    mdexp_pkg::t_word n_r;
    mdexp_pkg::t_word w_x;
    mdexp_pkg::t_word w_y;
    logic [W+1:0] w_t;
    logic [W+1:0] w_addend;
    logic [W+1:0] w_m1;
    logic [W+1:0] w_m2;
    logic [W+1:0] w_d1;
    logic [W+1:0] w_d2;

    always_comb begin
        case (i_cmd.op_sel)
            mdexp_pkg::OP_BASE: begin
                w_x = r_base;
                w_y = W'(1);
            end
            mdexp_pkg::OP_ACC: begin
                w_x = r_acc;
                w_y = r_sq;
            end
            default: begin
                w_x = r_sq;
                w_y = r_sq;
            end
        endcase
    end

    always_comb begin
        w_addend = r_mx[W-1] ? {2'b00, r_my} : '0;
        w_t      = {1'b0, r_r, 1'b0} + w_addend;
        w_m1     = {2'b00, i_modulus};
        w_m2     = {1'b0, i_modulus, 1'b0};
        w_d1     = w_t - w_m1;
        w_d2     = w_t - w_m2;
        if (i_modulus == '0) begin
            n_r = w_t[W-1:0];
        end else if (w_t >= w_m2) begin
            n_r = w_d2[W-1:0];
        end else if (w_t >= w_m1) begin
            n_r = w_d1[W-1:0];
        end else begin
            n_r = w_t[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base;
            r_acc  <= W'(1);
            r_exp  <= i_exponent;
        end
        if (i_cmd.mul_start) begin
            r_mx  <= w_x;
            r_my  <= w_y;
            r_r   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_mx  <= {r_mx[W-2:0], 1'b0};
            r_r   <= n_r;
            r_cnt <= r_cnt + mdexp_pkg::CNT_W'(1);
        end
        if (i_cmd.wr_sq) begin
            r_sq <= r_r;
        end
        if (i_cmd.wr_acc) begin
            r_acc <= r_r;
        end
        if (i_cmd.shift_exp) begin
            r_exp <= {1'b0, r_exp[W-1:1]};
        end
    end

    assign o_stat.cfg_exp_zero  = (i_exponent == '0);
    assign o_stat.exp_bit0      = r_exp[0];
    assign o_stat.exp_bit1      = r_exp[1];
    assign o_stat.exp_rest_zero = (r_exp[W-1:1] == '0);
    assign o_stat.mul_last      = (r_cnt == mdexp_pkg::CNT_W'(W-1));
    assign o_acc                = r_acc;

endmodule

FILE: sv/mdexp_ctrl.sv
// Controller: sequences base reduction and square-and-multiply steps.
// Uses mdexp_pkg command and status types; drives mdexp_datapath.
module mdexp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_free,
    input  mdexp_pkg::t_dp_stat i_stat,
    output mdexp_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MSTART = 3'd1;
    localparam logic [2:0] S_MSTEP  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_op;
    logic [1:0] n_op;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op_sel = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.cfg_exp_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_op    = mdexp_pkg::OP_BASE;
                        n_state = S_MSTART;
                    end
                end
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_MSTART;
                case (r_op)
                    mdexp_pkg::OP_BASE: begin
                        o_cmd.wr_sq = 1'b1;
                        n_op = i_stat.exp_bit0 ? mdexp_pkg::OP_ACC : mdexp_pkg::OP_SQR;
                    end
                    mdexp_pkg::OP_ACC: begin
                        o_cmd.wr_acc = 1'b1;
                        n_op = mdexp_pkg::OP_SQR;
                        if (i_stat.exp_rest_zero) begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        o_cmd.wr_sq     = 1'b1;
                        o_cmd.shift_exp = 1'b1;
                        n_op = i_stat.exp_bit1 ? mdexp_pkg::OP_ACC : mdexp_pkg::OP_SQR;
                    end
                endcase
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= mdexp_pkg::OP_BASE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: sv/modular_exponentiation.sv
// Modular exponentiation top level: config registers, output register, controller, datapath.
// Each modular multiply runs a start step, 32 shift-add steps and a write-back step.
// A zero exponent skips all multiplies; one item at a time, the next is accepted once the
// result is registered.
// Reset (synchronous, active low): modulus 1, exponent 0, controller idle, no result.
// Depends on mdexp_pkg, mdexp_ctrl and mdexp_datapath.
module modular_exponentiation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mdexp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  mdexp_pkg::t_word                   i_cfg_wdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [31:0]                        i_s_tdata,   // [31:0] base_value
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [31:0]                        o_m_tdata    // [31:0] power_result
);

    mdexp_pkg::t_word    r_modulus;
    mdexp_pkg::t_word    r_exponent;
    logic                r_out_valid;
    mdexp_pkg::t_word    r_out_data;
    mdexp_pkg::t_dp_cmd  w_cmd;
    mdexp_pkg::t_dp_stat w_stat;
    mdexp_pkg::t_word    w_acc;
    logic                w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= mdexp_pkg::WORD_WIDTH'(1);
            r_exponent <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mdexp_pkg::REG_MODULUS:  r_modulus  <= i_cfg_wdata;
                mdexp_pkg::REG_EXPONENT: r_exponent <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_data <= w_acc;
        end
    end

    mdexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mdexp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_base     (i_s_tdata[mdexp_pkg::WORD_WIDTH-1:0]),
        .i_modulus  (r_modulus),
        .i_exponent (r_exponent),
        .o_stat     (w_stat),
        .o_acc      (w_acc)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = 32'(r_out_data);

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted again while an item is in flight");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten before transfer");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_modulus > mdexp_pkg::WORD_WIDTH'(1)) |-> (r_out_data < r_modulus))
        else $error("result not reduced by modulus");
`endif

endmodule
